### src/tabular_q_learning_agent_unit_assert.svh
`ifndef TABULAR_Q_LEARNING_AGENT_UNIT_ASSERT_SVH
`define TABULAR_Q_LEARNING_AGENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define TQLA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define TQLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tqla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tqla_pkg;

    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 32;
    localparam int STATE_FIELD_BITS = 8;
    localparam int ACTION_FIELD_BITS = 4;
    localparam int REWARD_BITS      = 16;
    localparam int RESULT_VALUE_BITS = 16;
    localparam int NUM_ACTIONS_BITS = 5;
    localparam int COEF_BITS        = 16;
    localparam int EXPLORE_BITS     = 25;
    localparam int RNG_BITS         = 32;
    localparam int FRAC_BITS        = 24;
    localparam int FRAC_LSB         = 8;

    // shared multiplier: 34 x 22 signed, 56-bit product
    localparam int MUL_A_BITS = 34;
    localparam int MUL_B_BITS = 22;
    localparam int MUL_P_BITS = 56;
    // working width for target and new value before saturation
    localparam int WIDE_BITS  = 36;
    localparam int FIX_SHIFT  = 16;

    localparam logic [RNG_BITS-1:0] LCG_MUL = 32'd1664525;
    localparam logic [RNG_BITS-1:0] LCG_INC = 32'd1013904223;

    localparam logic OP_SELECT = 1'b0;

    localparam logic [NUM_ACTIONS_BITS-1:0] NUM_ACTIONS_RST = 5'd4;
    localparam logic [COEF_BITS-1:0]        LEARN_RATE_RST  = 16'd6554;
    localparam logic [COEF_BITS-1:0]        DISCOUNT_RST    = 16'd58982;
    localparam logic [EXPLORE_BITS-1:0]     EXPLORE_RST     = 25'd1677722;
    localparam logic [RNG_BITS-1:0]         RNG_RST         = 32'd1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NUM_ACTIONS   = 3'd0,
        CFG_LEARN_RATE    = 3'd1,
        CFG_DISCOUNT      = 3'd2,
        CFG_EXPLORE       = 3'd3,
        CFG_RNG_SEED      = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_DRAW_ADD,
        ST_RAND,
        ST_RAND_DONE,
        ST_SCAN,
        ST_DISC,
        ST_TARGET,
        ST_READQ,
        ST_WAITQ,
        ST_LEARN,
        ST_APPLY,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                                action;
        logic [STATE_FIELD_BITS-1:0]         state_index;
        logic [ACTION_FIELD_BITS-1:0]        taken_action;
        logic signed [REWARD_BITS-1:0]       reward;
        logic [STATE_FIELD_BITS-1:0]         next_state;
        logic                                episode_done;
    } item_t;

    typedef struct packed {
        logic [ACTION_FIELD_BITS-1:0]        chosen_action;
        logic                                explored;
        logic signed [RESULT_VALUE_BITS-1:0] updated_value;
    } result_t;

endpackage

`default_nettype wire

### src/tqla_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tqla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wr_data,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/tqla_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier, product registered.
module tqla_mul (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [tqla_pkg::MUL_A_BITS-1:0] a,
    input  logic signed [tqla_pkg::MUL_B_BITS-1:0] b,
    output logic signed [tqla_pkg::MUL_P_BITS-1:0] prod
);
    import tqla_pkg::*;

    logic signed [MUL_P_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### src/tabular_q_learning_agent_unit.sv
// Tabular Q-learning agent, epsilon-greedy selection.
// Request channel (item_valid / item_stall / item): taken when valid is high and stall
// low. A select request draws from a 32-bit LCG and either picks a random action or
// the first best action of the state's row; an update request moves one Q entry
// toward reward + discount * max Q(next_state), or toward reward alone at episode end.
// Result channel (result_valid / result_stall / result): one result per request,
// held in an output register until taken; a new request is taken while it waits.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; write
// only while the block is idle. Writing the seed reloads the generator.
// One request at a time: the row scan reads the Q RAM one entry per cycle and every
// product goes through the single shared multiplier, so a new request is taken only
// after the last one has been loaded into the output register.
// Reset: config returns to defaults, then the Q table is cleared one entry per cycle
// (STATE_COUNT * ACTION_MAX entries, 4096 by default) with item_stall high.
// A stalled result holds; a finished request waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "tabular_q_learning_agent_unit_assert.svh"

module tabular_q_learning_agent_unit #(
    parameter int STATE_COUNT = 256,
    parameter int ACTION_MAX  = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  tqla_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output tqla_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tqla_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tqla_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import tqla_pkg::*;

    localparam int DEPTH     = STATE_COUNT * ACTION_MAX;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_BITS  = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int COL_BITS  = (ACTION_MAX > 1) ? $clog2(ACTION_MAX) : 1;
    localparam int CNT_BITS  = $clog2(ACTION_MAX + 1);

    localparam logic signed [WIDE_BITS-1:0] VAL_MAX =
        (WIDE_BITS'(1) <<< (VALUE_BITS - 1)) - WIDE_BITS'(1);
    localparam logic signed [WIDE_BITS-1:0] VAL_MIN = ~VAL_MAX;

    // clamp to the signed table range
    function automatic logic signed [VALUE_BITS-1:0] sat_value(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [WIDE_BITS-1:0] r;
        if (v > VAL_MAX)
            r = VAL_MAX;
        else if (v < VAL_MIN)
            r = VAL_MIN;
        else
            r = v;
        return VALUE_BITS'(r);
    endfunction

    // state field modulo STATE_COUNT: restoring reduction, one bit per step
    function automatic logic [ROW_BITS-1:0] row_of(
        input logic [STATE_FIELD_BITS-1:0] s
    );
        logic [31:0] r;
        r = 32'(s);
        for (int i = STATE_FIELD_BITS - 1; i >= 0; i--)
        begin
            if (r >= (32'(STATE_COUNT) << i))
                r = r - (32'(STATE_COUNT) << i);
        end
        return ROW_BITS'(r);
    endfunction

    // config
    logic [NUM_ACTIONS_BITS-1:0] num_actions_reg, num_actions_next;
    logic [COEF_BITS-1:0]        learn_rate_reg, learn_rate_next;
    logic [COEF_BITS-1:0]        discount_reg, discount_next;
    logic [EXPLORE_BITS-1:0]     explore_thr_reg, explore_thr_next;
    logic [RNG_BITS-1:0]         rng_reg, rng_next;

    // sequencer
    seq_state_t                  state_reg, state_next;
    logic [ADDR_BITS-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                        draw_sel_reg, draw_sel_next;
    logic [COL_BITS-1:0]         issue_col_reg, issue_col_next;
    logic                        issue_done_reg, issue_done_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [COL_BITS-1:0]         rd_col_reg, rd_col_next;

    // datapath
    item_t                       item_reg, item_next;
    logic [FRAC_BITS-1:0]        frac_reg, frac_next;
    logic signed [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic [COL_BITS-1:0]         best_col_reg, best_col_next;
    logic signed [VALUE_BITS-1:0] target_reg, target_next;
    logic signed [VALUE_BITS-1:0] q_reg, q_next;
    logic signed [MUL_A_BITS-1:0] diff_reg, diff_next;
    result_t                     res_reg, res_next;

    // output register
    logic                        result_valid_reg, result_valid_next;
    result_t                     result_reg, result_next;
    logic                        finish_load;

    // count of actions in use, clamped to 1..ACTION_MAX
    logic [CNT_BITS-1:0]         act_count;
    logic [COL_BITS-1:0]         act_last;
    logic [COL_BITS-1:0]         taken_col;
    logic [STATE_FIELD_BITS-1:0] scan_state;
    logic [ROW_BITS-1:0]         scan_row;
    logic [ROW_BITS-1:0]         upd_row;
    logic [ADDR_BITS-1:0]        scan_addr;
    logic [ADDR_BITS-1:0]        upd_addr;

    logic [RNG_BITS-1:0]         lcg_sum;
    logic [FRAC_BITS-1:0]        draw_frac;
    logic [CNT_BITS-1:0]         rand_pick;
    logic [COL_BITS-1:0]         rand_col;
    logic signed [VALUE_BITS-1:0] boot_target;
    logic signed [VALUE_BITS-1:0] apply_val;

    // RAM and multiplier hookup
    logic                        ram_wr_en;
    logic                        ram_rd_en;
    logic [ADDR_BITS-1:0]        ram_addr;
    logic [VALUE_BITS-1:0]       ram_wr_data;
    logic [VALUE_BITS-1:0]       ram_rd_data;
    logic signed [VALUE_BITS-1:0] rd_val;
    logic                        mul_en;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [MUL_P_BITS-1:0] mul_prod;

    tqla_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_qtab (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .rd_en   (ram_rd_en),
        .addr    (ram_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    tqla_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    always_comb
    begin
        if (num_actions_reg == '0)
            act_count = CNT_BITS'(1);
        else if (32'(num_actions_reg) > 32'(ACTION_MAX))
            act_count = CNT_BITS'(ACTION_MAX);
        else
            act_count = CNT_BITS'(num_actions_reg);
        act_last = COL_BITS'(act_count - CNT_BITS'(1));
    end

    // out-of-range taken action sticks to the last column
    assign taken_col = (32'(item_reg.taken_action) >= 32'(act_count)) ?
                       act_last : COL_BITS'(item_reg.taken_action);

    // select scans its own row, update scans the successor row
    assign scan_state = (item_reg.action == OP_SELECT) ?
                        item_reg.state_index : item_reg.next_state;
    assign scan_row   = row_of(scan_state);
    assign upd_row    = row_of(item_reg.state_index);
    assign scan_addr  = ADDR_BITS'(32'(scan_row) * 32'(ACTION_MAX) + 32'(issue_col_reg));
    assign upd_addr   = ADDR_BITS'(32'(upd_row) * 32'(ACTION_MAX) + 32'(taken_col));

    assign rd_val    = $signed(ram_rd_data);
    assign lcg_sum   = mul_prod[RNG_BITS-1:0] + LCG_INC;
    assign draw_frac = lcg_sum[FRAC_LSB +: FRAC_BITS];
    assign rand_pick = mul_prod[FRAC_BITS +: CNT_BITS];
    assign rand_col  = (rand_pick >= act_count) ? act_last : COL_BITS'(rand_pick);

    // products are floored by the arithmetic shift
    assign boot_target = sat_value(WIDE_BITS'($signed(item_reg.reward))
                                   + WIDE_BITS'(mul_prod >>> FIX_SHIFT));
    assign apply_val   = sat_value(WIDE_BITS'(q_reg) + WIDE_BITS'(mul_prod >>> FIX_SHIFT));

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        draw_sel_next     = draw_sel_reg;
        issue_col_next    = issue_col_reg;
        issue_done_next   = issue_done_reg;
        rd_vld_next       = rd_vld_reg;
        rd_col_next       = rd_col_reg;
        item_next         = item_reg;
        frac_next         = frac_reg;
        best_val_next     = best_val_reg;
        best_col_next     = best_col_reg;
        target_next       = target_reg;
        q_next            = q_reg;
        diff_next         = diff_reg;
        res_next          = res_reg;
        rng_next          = rng_reg;
        num_actions_next  = num_actions_reg;
        learn_rate_next   = learn_rate_reg;
        discount_next     = discount_reg;
        explore_thr_next  = explore_thr_reg;

        item_stall  = 1'b1;
        finish_load = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_addr    = scan_addr;
        ram_wr_data = '0;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                ram_addr  = clr_cnt_reg;
                if (clr_cnt_reg == ADDR_BITS'(DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
            end

            ST_IDLE:
            begin
                item_stall      = 1'b0;
                draw_sel_next   = 1'b0;
                issue_col_next  = '0;
                issue_done_next = 1'b0;
                rd_vld_next     = 1'b0;
                res_next        = '0;
                if (item_valid)
                begin
                    item_next = item;
                    if (item.action == OP_SELECT)
                        state_next = ST_DRAW;
                    else if (item.episode_done)
                    begin
                        target_next = sat_value(WIDE_BITS'($signed(item.reward)));
                        state_next  = ST_READQ;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_DRAW:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(rng_reg);
                mul_b      = MUL_B_BITS'(LCG_MUL);
                state_next = ST_DRAW_ADD;
            end

            ST_DRAW_ADD:
            begin
                rng_next = lcg_sum;
                if (draw_sel_reg)
                begin
                    frac_next  = draw_frac;
                    state_next = ST_RAND;
                end
                else if ({1'b0, draw_frac} < explore_thr_reg)
                begin
                    draw_sel_next = 1'b1;
                    state_next    = ST_DRAW;
                end
                else
                    state_next = ST_SCAN;
            end

            ST_RAND:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(frac_reg);
                mul_b      = MUL_B_BITS'(act_count);
                state_next = ST_RAND_DONE;
            end

            ST_RAND_DONE:
            begin
                res_next.chosen_action = ACTION_FIELD_BITS'(rand_col);
                res_next.explored      = 1'b1;
                state_next             = ST_FINISH;
            end

            // one read issued per cycle, data compared in the next cycle
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_addr    = scan_addr;
                    rd_vld_next = 1'b1;
                    rd_col_next = issue_col_reg;
                    if (issue_col_reg == act_last)
                        issue_done_next = 1'b1;
                    else
                        issue_col_next = issue_col_reg + COL_BITS'(1);
                end
                else
                    rd_vld_next = 1'b0;

                if (rd_vld_reg)
                begin
                    // strict compare keeps the first maximum
                    if (rd_col_reg == '0 || rd_val > best_val_reg)
                    begin
                        best_val_next = rd_val;
                        best_col_next = rd_col_reg;
                    end
                    if (rd_col_reg == act_last)
                    begin
                        if (item_reg.action == OP_SELECT)
                        begin
                            res_next.chosen_action = ACTION_FIELD_BITS'(best_col_next);
                            state_next             = ST_FINISH;
                        end
                        else
                            state_next = ST_DISC;
                    end
                end
            end

            ST_DISC:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(best_val_reg);
                mul_b      = MUL_B_BITS'(discount_reg);
                state_next = ST_TARGET;
            end

            ST_TARGET:
            begin
                target_next = boot_target;
                state_next  = ST_READQ;
            end

            ST_READQ:
            begin
                ram_rd_en  = 1'b1;
                ram_addr   = upd_addr;
                state_next = ST_WAITQ;
            end

            ST_WAITQ:
            begin
                q_next     = rd_val;
                diff_next  = MUL_A_BITS'(target_reg) - MUL_A_BITS'(rd_val);
                state_next = ST_LEARN;
            end

            ST_LEARN:
            begin
                mul_en     = 1'b1;
                mul_a      = diff_reg;
                mul_b      = MUL_B_BITS'(learn_rate_reg);
                state_next = ST_APPLY;
            end

            ST_APPLY:
            begin
                ram_wr_en              = 1'b1;
                ram_addr               = upd_addr;
                ram_wr_data            = apply_val;
                res_next.updated_value = RESULT_VALUE_BITS'(apply_val);
                state_next             = ST_FINISH;
            end

            // wait for the output register to free up
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    finish_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUM_ACTIONS: num_actions_next = cfg_data[NUM_ACTIONS_BITS-1:0];
                CFG_LEARN_RATE:  learn_rate_next  = cfg_data[COEF_BITS-1:0];
                CFG_DISCOUNT:    discount_next    = cfg_data[COEF_BITS-1:0];
                CFG_EXPLORE:     explore_thr_next = cfg_data[EXPLORE_BITS-1:0];
                CFG_RNG_SEED:    rng_next = (cfg_data == '0) ? RNG_RST : cfg_data;
                default:         ;
            endcase
        end

        if (finish_load)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;

        result_next = finish_load ? res_reg : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            draw_sel_reg     <= 1'b0;
            issue_col_reg    <= '0;
            issue_done_reg   <= 1'b0;
            rd_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            rng_reg          <= RNG_RST;
            num_actions_reg  <= NUM_ACTIONS_RST;
            learn_rate_reg   <= LEARN_RATE_RST;
            discount_reg     <= DISCOUNT_RST;
            explore_thr_reg  <= EXPLORE_RST;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            draw_sel_reg     <= draw_sel_next;
            issue_col_reg    <= issue_col_next;
            issue_done_reg   <= issue_done_next;
            rd_vld_reg       <= rd_vld_next;
            result_valid_reg <= result_valid_next;
            rng_reg          <= rng_next;
            num_actions_reg  <= num_actions_next;
            learn_rate_reg   <= learn_rate_next;
            discount_reg     <= discount_next;
            explore_thr_reg  <= explore_thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        frac_reg     <= frac_next;
        rd_col_reg   <= rd_col_next;
        best_val_reg <= best_val_next;
        best_col_reg <= best_col_next;
        target_reg   <= target_next;
        q_reg        <= q_next;
        diff_reg     <= diff_next;
        res_reg      <= res_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // a result only ever comes out of the finish step
    `TQLA_ASSERT_IMP(a_result_from_finish, $rose(result_valid_reg), $past(state_reg) == ST_FINISH, "result raised outside finish")
    // an accepted request always starts work
    `TQLA_ASSERT_NEXT(a_accept_starts_work, item_valid && !item_stall, state_reg != ST_IDLE && state_reg != ST_CLEAR, "accepted request did not start")
    // nothing is reported while the table is being cleared
    `TQLA_ASSERT_IMP(a_no_result_in_clear, state_reg == ST_CLEAR, !result_valid_reg, "result during table clear")

endmodule

`default_nettype wire

### dv/tabular_q_learning_agent_unit_checker.sv
`timescale 1ns / 1ps

module tabular_q_learning_agent_unit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  tqla_pkg::item_t                     item,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  tqla_pkg::result_t                   result,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tqla_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tqla_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  open_count
);
    import tqla_pkg::*;

    localparam int STATE_COUNT = 256;
    localparam int ACTION_MAX  = 16;
    localparam longint VALUE_HI = 32767;
    localparam longint VALUE_LO = -32768;

    // shadow copy of the agent
    logic signed [RESULT_VALUE_BITS-1:0] q_mem [0:STATE_COUNT*ACTION_MAX-1];
    logic [RNG_BITS-1:0]         lcg_state;
    logic [NUM_ACTIONS_BITS-1:0] num_actions;
    logic [COEF_BITS-1:0]        learn_rate;
    logic [COEF_BITS-1:0]        discount;
    logic [EXPLORE_BITS-1:0]     explore_threshold;

    result_t awaited_results[$];
    int      errors = 0;

    function automatic logic [FRAC_BITS-1:0] draw_fraction();
        lcg_state = lcg_state * LCG_MUL + LCG_INC;
        return lcg_state[RNG_BITS-1:FRAC_LSB];
    endfunction

    function automatic longint clamp_value(input longint v);
        if (v > VALUE_HI) return VALUE_HI;
        if (v < VALUE_LO) return VALUE_LO;
        return v;
    endfunction

    // first highest entry among the first n columns of a row
    function automatic void row_peak(input int base, input int n,
                                     output int best_idx, output int best_val);
        best_idx = 0;
        best_val = q_mem[base];
        for (int k = 1; k < n; k++) begin
            if (q_mem[base + k] > best_val) begin
                best_val = q_mem[base + k];
                best_idx = k;
            end
        end
    endfunction

    function automatic result_t q_agent_outcome(input item_t req);
        result_t              res;
        int                   n, base, a, best_idx, best_val;
        logic [FRAC_BITS-1:0] frac;
        longint               target, q_old, q_new;
        res = '0;
        n = (num_actions == 0) ? 1 : ((num_actions > ACTION_MAX) ? ACTION_MAX : num_actions);
        base = (int'(req.state_index) % STATE_COUNT) * ACTION_MAX;
        if (req.action == OP_SELECT) begin
            frac = draw_fraction();
            if ({1'b0, frac} < explore_threshold) begin
                frac = draw_fraction();
                a = int'((longint'(frac) * n) >>> FRAC_BITS);
                if (a >= n) a = n - 1;
                res.chosen_action = a[ACTION_FIELD_BITS-1:0];
                res.explored = 1'b1;
            end else begin
                row_peak(base, n, best_idx, best_val);
                res.chosen_action = best_idx[ACTION_FIELD_BITS-1:0];
            end
        end else begin
            a = req.taken_action;
            if (a >= n) a = n - 1;
            target = longint'($signed(req.reward));
            if (!req.episode_done) begin
                row_peak((int'(req.next_state) % STATE_COUNT) * ACTION_MAX, n,
                         best_idx, best_val);
                target += (longint'(discount) * longint'(best_val)) >>> FIX_SHIFT;
            end
            target = clamp_value(target);
            q_old = longint'(q_mem[base + a]);
            q_new = clamp_value(q_old +
                                ((longint'(learn_rate) * (target - q_old)) >>> FIX_SHIFT));
            q_mem[base + a] = q_new[RESULT_VALUE_BITS-1:0];
            res.updated_value = q_new[RESULT_VALUE_BITS-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            for (int i = 0; i < STATE_COUNT * ACTION_MAX; i++) q_mem[i] = '0;
            lcg_state         = RNG_RST;
            num_actions       = NUM_ACTIONS_RST;
            learn_rate        = LEARN_RATE_RST;
            discount          = DISCOUNT_RST;
            explore_threshold = EXPLORE_RST;
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_ACTIONS: num_actions       = cfg_data[NUM_ACTIONS_BITS-1:0];
                    CFG_LEARN_RATE:  learn_rate        = cfg_data[COEF_BITS-1:0];
                    CFG_DISCOUNT:    discount          = cfg_data[COEF_BITS-1:0];
                    CFG_EXPLORE:     explore_threshold = cfg_data[EXPLORE_BITS-1:0];
                    CFG_RNG_SEED:    lcg_state = (cfg_data == '0) ? RNG_RST : cfg_data;
                    default: ;
                endcase
            end
            // results first: a request taken this edge cannot finish this edge
            if (result_valid && !result_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, result);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (result.chosen_action !== want.chosen_action) begin
                        $display("%0t: chosen_action expected %0d actual %0d",
                                 $time, want.chosen_action, result.chosen_action);
                        errors++;
                    end
                    if (result.explored !== want.explored) begin
                        $display("%0t: explored expected %0b actual %0b",
                                 $time, want.explored, result.explored);
                        errors++;
                    end
                    if (result.updated_value !== want.updated_value) begin
                        $display("%0t: updated_value expected %0d actual %0d",
                                 $time, want.updated_value, result.updated_value);
                        errors++;
                    end
                end
            end
            if (item_valid && !item_stall) awaited_results.push_back(q_agent_outcome(item));
        end
        fail_count <= errors;
        open_count <= awaited_results.size();
    end

endmodule

### dv/tabular_q_learning_agent_unit_tb.sv
`timescale 1ns / 1ps

// Top of the agent testbench. It only makes stimulus and calls the verdict;
// prediction and comparison sit in the checker instance beside the block.
module tabular_q_learning_agent_unit_tb;
    import tqla_pkg::*;

    // generous: ~1000 requests at worst-case latency and stalls, plus the
    // post-reset table clear (4096 entries) and the long result hold-off
    localparam int   CYCLE_LIMIT   = 500000;
    // longest request is an update of a non-final step; give it extra margin
    localparam int   SETTLE_CYCLES = 40;
    localparam int   LONG_HOLD     = 400;
    localparam int   PHASES        = 8;
    localparam int   PHASE_ITEMS   = 118;
    localparam logic OP_UPDATE     = ~OP_SELECT;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    item_t                     item         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    int fail_count;
    int open_count;
    int cycle_count = 0;

    // idle percentages for the current phase
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    // one long hold-off on the result side, served once by the stall process
    logic hold_now    = 1'b0;
    logic hold_served = 1'b0;

    tabular_q_learning_agent_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tabular_q_learning_agent_unit_checker q_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .open_count   (open_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tabular_q_learning_agent_unit_tb: FAIL");
            $finish;
        end
    end

    // Result side. Random stall per cycle, except for the single long hold-off:
    // the block finishes one request into its output register, takes the next,
    // then has to push back on the request side.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_now && !hold_served)
            begin
                hold_served = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic item_t make_request(input logic op, input int st, input int act,
                                           input int rew, input int nxt, input logic done);
        item_t r;
        r.action       = op;
        r.state_index  = st[STATE_FIELD_BITS-1:0];
        r.taken_action = act[ACTION_FIELD_BITS-1:0];
        r.reward       = rew[REWARD_BITS-1:0];
        r.next_state   = nxt[STATE_FIELD_BITS-1:0];
        r.episode_done = done;
        return r;
    endfunction

    // Most traffic hits a handful of states so that rows build up real values
    // and the greedy scan and bootstrap see nonzero, tied and saturated entries.
    function automatic item_t random_request();
        item_t r;
        r.action       = ($urandom_range(99) < 60) ? OP_UPDATE : OP_SELECT;
        r.state_index  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        r.taken_action = 4'($urandom);
        r.reward       = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1024) - 512);
        r.next_state   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        r.episode_done = ($urandom_range(3) == 0);
        return r;
    endfunction

    // Offer one request; returns at the edge that takes it. Valid stays high
    // into the next call unless that call opens a gap.
    task automatic offer(input item_t req);
        if ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (item_stall);
    endtask

    // Stop sending and wait for every awaited result, then let the block settle.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // valid is left high; the caller lowers it after the last write
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [NUM_ACTIONS_BITS-1:0] nact,
                                 input logic [COEF_BITS-1:0] lr,
                                 input logic [COEF_BITS-1:0] disc,
                                 input logic [EXPLORE_BITS-1:0] eps,
                                 input logic [RNG_BITS-1:0] seed);
        write_reg(CFG_NUM_ACTIONS, 32'(nact));
        write_reg(CFG_LEARN_RATE,  32'(lr));
        write_reg(CFG_DISCOUNT,    32'(disc));
        write_reg(CFG_EXPLORE,     32'(eps));
        write_reg(CFG_RNG_SEED,    seed);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // table clear runs with item_stall high; keep config writes off it
        while (item_stall) @(posedge clk);

        // directed, reset settings: 4 actions, alpha ~0.1, gamma ~0.9, eps ~0.1
        offer(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0));
        offer(make_request(OP_UPDATE, 0, 2, 32767, 0, 1'b0));
        // taken action past the count folds onto the last column
        offer(make_request(OP_UPDATE, 0, 15, -32768, 255, 1'b1));
        offer(make_request(OP_SELECT, 0, 0, 0, 0, 1'b0));
        offer(make_request(OP_UPDATE, 255, 0, 1, 0, 1'b0));
        drain();

        // full step sizes, all 16 columns, never explore: drive target and Q
        // into both saturation rails
        load_settings(5'd16, 16'hFFFF, 16'hFFFF, '0, 32'h1234_5678);
        offer(make_request(OP_UPDATE, 1, 15, 32767, 0, 1'b1));
        offer(make_request(OP_UPDATE, 2, 7, 32767, 1, 1'b0));
        offer(make_request(OP_UPDATE, 3, 0, -32768, 3, 1'b1));
        offer(make_request(OP_UPDATE, 3, 0, -32768, 3, 1'b0));
        offer(make_request(OP_SELECT, 1, 0, 0, 0, 1'b0));
        offer(make_request(OP_SELECT, 3, 0, 0, 0, 1'b0));
        drain();

        // zero count acts as one, frozen table, always explore, zero seed
        load_settings('0, '0, '0, 25'h100_0000, '0);
        offer(make_request(OP_SELECT, 5, 0, 0, 0, 1'b0));
        offer(make_request(OP_UPDATE, 1, 9, 100, 1, 1'b0));
        drain();

        // count above the table width clamps to 16; threshold at its top code
        load_settings('1, 16'd1, 16'd1, '1, '1);
        offer(make_request(OP_SELECT, 7, 0, 0, 0, 1'b0));
        offer(make_request(OP_SELECT, 7, 0, 0, 0, 1'b0));
        offer(make_request(OP_SELECT, 2, 0, 0, 0, 1'b0));
        offer(make_request(OP_UPDATE, 2, 3, -1, 1, 1'b0));
        drain();

        // random phases; idle pattern cycles through none / sender / receiver / both
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_settings(5'd16, '1, '1, 25'h100_0000, $urandom);
                1: load_settings(5'd1, '0, '0, '0, '0);
                default: load_settings(5'($urandom_range(31)), 16'($urandom),
                                       16'($urandom), 25'($urandom_range(0, 1 << 24)),
                                       $urandom);
            endcase
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 65; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            // back-pressure test: result side holds off while requests keep coming
            if (ph == 4) hold_now <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender pause mid-phase until the block is empty
                if (ph == 5 && i == PHASE_ITEMS / 2) drain();
                offer(random_request());
            end
            drain();
        end

        if (fail_count == 0)
            $display("tabular_q_learning_agent_unit_tb: PASS");
        else
            $display("tabular_q_learning_agent_unit_tb: FAIL");
        $finish;
    end

endmodule

### tabular_q_learning_agent_unit.f
+incdir+src
src/tqla_pkg.sv
src/tqla_ram.sv
src/tqla_mul.sv
src/tabular_q_learning_agent_unit.sv
dv/tabular_q_learning_agent_unit_checker.sv
dv/tabular_q_learning_agent_unit_tb.sv
